// ===== rtl/core/signed_subset_sum_counter_top_macros.svh =====
// assertion macros for the signed subset sum counter
`ifndef SIGNED_SUBSET_SUM_COUNTER_TOP_MACROS_SVH
`define SIGNED_SUBSET_SUM_COUNTER_TOP_MACROS_SVH

// property checked on every rising edge outside reset
`define SSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold outside reset
`define SSSC_ASSERT_NEVER(lbl, cond, msg) \
  `SSSC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/sssc_pkg.sv =====
// shared types and constants of the signed subset sum counter
package sssc_pkg;

  localparam int unsigned MAX_SUM_DEF     = 1023;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W         = 10;
  localparam int unsigned TARGET_W        = 11;
  localparam int unsigned WAYS_W          = 32;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [WAYS_W-1:0] ways;
    logic              overflow;
  } out_item_t;

  // control handed to the table sweep unit
  typedef struct packed {
    logic                       start;
    logic                       sel;
    logic                       fresh;
    logic [VALUE_W-1:0]         value;
    logic signed [TARGET_W-1:0] target;
  } sweep_ctrl_t;

endpackage

// ===== rtl/core/signed_subset_sum_counter_top.sv =====
// signed subset sum counter: request handshake, set bookkeeping and result register
//
// input channel: in_valid_i / in_stall_o with in_data_i {value, last}; a request
// is taken when valid is high and stall is low. the block takes one request at a
// time and stalls the input until the table sweep of that request is done.
// output channel: out_valid_o / out_stall_i with out_data_o {ways, overflow};
// one result comes out for each request marked last, none for the others.
// configuration: cfg_valid_i / cfg_ready_o / cfg_data_i writes target_sum; write
// it only while no request is in flight.
// each request sweeps every entry of the count table once through the shared
// saturating adder, one entry per cycle, and a result is loaded into the output
// register when the sweep ends and the output register is free. a held result
// sits in the output register while the next request is taken; if a new
// result is ready while the old one is still stalled, the block waits and
// keeps the input stalled.
// reset empties the output, sets target_sum to zero and starts a fresh set with
// one way at sum zero; no clearing pass is needed since the first sweep of a set
// reads the initial table implicitly.
module signed_subset_sum_counter_top #(
  parameter int unsigned MAX_SUM     = sssc_pkg::MAX_SUM_DEF,
  parameter int unsigned COUNT_WIDTH = sssc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  sssc_pkg::in_item_t                       in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output sssc_pkg::out_item_t                      out_data_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic signed [sssc_pkg::TARGET_W-1:0]     cfg_data_i
);
  import sssc_pkg::*;

  `include "signed_subset_sum_counter_top_macros.svh"

  localparam int unsigned TOT_W = $clog2(MAX_SUM + 2);
  localparam int unsigned SUM_W = ((TOT_W > VALUE_W) ? TOT_W : VALUE_W) + 1;
  localparam int unsigned EXT_W = (COUNT_WIDTH > WAYS_W) ? COUNT_WIDTH : WAYS_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic signed [TARGET_W-1:0] target_q;
  logic                       sel_q, sel_d;
  logic                       fresh_q, fresh_d;
  logic [TOT_W-1:0]           tot_q, tot_d;
  logic                       ovf_q, ovf_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;

  logic                       in_acc;
  logic                       out_free;
  logic [SUM_W-1:0]           tot_sum;
  sweep_ctrl_t                ctrl;
  logic                       done;
  logic [COUNT_WIDTH-1:0]     cnt_ways;
  logic [EXT_W-1:0]           ways_ext;
  logic [WAYS_W-1:0]          ways_sat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign tot_sum     = SUM_W'(tot_q) + SUM_W'(in_data_i.value);

  assign ctrl.start  = in_acc;
  assign ctrl.sel    = sel_q;
  assign ctrl.fresh  = fresh_q;
  assign ctrl.value  = in_data_i.value;
  assign ctrl.target = target_q;

  sssc_sweep #(
    .MAX_SUM    (MAX_SUM),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_sweep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .done_o(done),
    .ways_o(cnt_ways)
  );

  // clamp wide counts to the result width
  assign ways_ext = EXT_W'(cnt_ways);
  assign ways_sat = (ways_ext > EXT_W'({WAYS_W{1'b1}})) ? '1 : ways_ext[WAYS_W-1:0];

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    fresh_d     = fresh_q;
    tot_d       = tot_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          last_d  = in_data_i.last;
          state_d = ST_SWEEP;
          if (tot_sum > SUM_W'(MAX_SUM)) begin
            ovf_d = 1'b1;
            tot_d = TOT_W'(MAX_SUM + 1);
          end else begin
            tot_d = tot_sum[TOT_W-1:0];
          end
        end
      end
      ST_SWEEP: begin
        if (done) begin
          sel_d   = !sel_q;
          fresh_d = 1'b0;
          if (!last_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_valid_d      = 1'b1;
            out_d.ways       = ways_sat;
            out_d.overflow   = ovf_q;
            sel_d            = 1'b0;
            fresh_d          = 1'b1;
            tot_d            = '0;
            ovf_d            = 1'b0;
            state_d          = ST_IDLE;
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.ways     = ways_sat;
          out_d.overflow = ovf_q;
          sel_d          = 1'b0;
          fresh_d        = 1'b1;
          tot_d          = '0;
          ovf_d          = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      sel_q       <= 1'b0;
      fresh_q     <= 1'b1;
      tot_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      fresh_q     <= fresh_d;
      tot_q       <= tot_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SSSC_ASSERT(a_acc_starts_sweep, in_acc |=> state_q == ST_SWEEP, "request did not start a sweep")
  `SSSC_ASSERT_NEVER(a_done_outside_sweep, done && state_q != ST_SWEEP, "done while not sweeping")
  `SSSC_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(in_stall_o), "result without sweep")
  `SSSC_ASSERT(a_ovf_total, ovf_q |-> tot_q == TOT_W'(MAX_SUM + 1), "overflow without full total")
  `SSSC_ASSERT(a_wait_needs_last, state_q == ST_WAIT |-> last_q, "wait without last request")

endmodule

// ===== rtl/core/sssc_sweep.sv =====
// ping-pong count tables with one shared saturating adder swept over all sums
module sssc_sweep #(
  parameter int unsigned MAX_SUM     = sssc_pkg::MAX_SUM_DEF,
  parameter int unsigned COUNT_WIDTH = sssc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sssc_pkg::sweep_ctrl_t   ctrl_i,
  output logic                    done_o,
  output logic [COUNT_WIDTH-1:0]  ways_o
);
  import sssc_pkg::*;

  localparam int unsigned DEPTH  = 2 * MAX_SUM + 1;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned A_W    = ((IDX_W > VALUE_W) ? IDX_W : VALUE_W) + 1;
  localparam int unsigned TIDX_W = ((IDX_W > TARGET_W) ? IDX_W : TARGET_W) + 2;

  logic [COUNT_WIDTH-1:0] mem_a [DEPTH];
  logic [COUNT_WIDTH-1:0] mem_b [DEPTH];

  logic                   run_q;
  logic [IDX_W-1:0]       cnt_q;
  logic [VALUE_W-1:0]     val_q;
  logic                   sel_q;
  logic                   fresh_q;
  logic [IDX_W-1:0]       tidx_q;
  logic                   tok_q;

  logic                   s1_vld_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic                   s1_lo_ok_q, s1_hi_ok_q;
  logic                   s1_lo_ctr_q, s1_hi_ctr_q;
  logic [COUNT_WIDTH-1:0] rd_lo_q, rd_hi_q;
  logic [COUNT_WIDTH-1:0] cap_q;

  logic [A_W-1:0]         lo_a, hi_a;
  logic                   lo_ok, hi_ok;
  logic [IDX_W-1:0]       lo_idx, hi_idx;
  logic signed [TIDX_W-1:0] tidx_s;
  logic                   tok;
  logic [COUNT_WIDTH-1:0] op_lo, op_hi, wr_data;
  logic [COUNT_WIDTH:0]   sum;
  logic                   hit;

  // target sum as a table index
  assign tidx_s = TIDX_W'(ctrl_i.target) + TIDX_W'(MAX_SUM);
  assign tok    = (tidx_s >= 0) && (tidx_s < TIDX_W'(DEPTH));

  // neighbor addresses s-v and s+v
  assign lo_a   = A_W'(cnt_q) - A_W'(val_q);
  assign hi_a   = A_W'(cnt_q) + A_W'(val_q);
  assign lo_ok  = A_W'(cnt_q) >= A_W'(val_q);
  assign hi_ok  = hi_a < A_W'(DEPTH);
  assign lo_idx = lo_ok ? lo_a[IDX_W-1:0] : '0;
  assign hi_idx = hi_ok ? hi_a[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      cnt_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= run_q;
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == IDX_W'(DEPTH - 1)) begin
          run_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      val_q   <= ctrl_i.value;
      sel_q   <= ctrl_i.sel;
      fresh_q <= ctrl_i.fresh;
      tidx_q  <= tidx_s[IDX_W-1:0];
      tok_q   <= tok;
    end
    s1_idx_q    <= cnt_q;
    s1_lo_ok_q  <= lo_ok;
    s1_hi_ok_q  <= hi_ok;
    s1_lo_ctr_q <= lo_ok && (lo_a == A_W'(MAX_SUM));
    s1_hi_ctr_q <= hi_ok && (hi_a == A_W'(MAX_SUM));
  end

  // read current table at both neighbors
  always_ff @(posedge clk_i) begin
    if (run_q) begin
      rd_lo_q <= sel_q ? mem_b[lo_idx] : mem_a[lo_idx];
      rd_hi_q <= sel_q ? mem_b[hi_idx] : mem_a[hi_idx];
    end
  end

  // a fresh set reads as one way at sum zero without touching memory
  always_comb begin
    if (!s1_lo_ok_q) begin
      op_lo = '0;
    end else if (fresh_q) begin
      op_lo = COUNT_WIDTH'(s1_lo_ctr_q);
    end else begin
      op_lo = rd_lo_q;
    end
    if (!s1_hi_ok_q) begin
      op_hi = '0;
    end else if (fresh_q) begin
      op_hi = COUNT_WIDTH'(s1_hi_ctr_q);
    end else begin
      op_hi = rd_hi_q;
    end
  end

  assign sum     = {1'b0, op_lo} + {1'b0, op_hi};
  assign wr_data = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && sel_q) begin
      mem_a[s1_idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && !sel_q) begin
      mem_b[s1_idx_q] <= wr_data;
    end
  end

  assign hit = s1_vld_q && tok_q && (s1_idx_q == tidx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cap_q <= '0;
    end else if (hit) begin
      cap_q <= wr_data;
    end
  end

  assign done_o = s1_vld_q && (s1_idx_q == IDX_W'(DEPTH - 1));
  assign ways_o = hit ? wr_data : cap_q;

endmodule
